FILE: design/vamr_pkg.sv
`timescale 1ns / 1ps
// Shared constants, payload types and rounding and saturation helpers of the vector alignment rotation unit.
package vamr_pkg;

    // Number formats
    localparam int FRAC_BITS = 14;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int PROD_W    = 2 * IN_W;            // product of two inputs
    localparam int CROSS_W   = PROD_W + 1;          // one cross product component
    localparam int DOT_W     = PROD_W + 2;          // dot product
    localparam int MAG_W     = PROD_W;              // magnitudes and squared norms
    localparam int SQ_W      = 2 * PROD_W;          // square root radicands
    localparam int ROOT_W    = PROD_W;              // square root results
    localparam int QUO_W     = FRAC_BITS + 1;       // quotients, at most 1.0
    localparam int NUM_W     = MAG_W + FRAC_BITS + 1;
    localparam int U_W       = FRAC_BITS + 2;       // s, c and axis components
    localparam int OMC_W     = FRAC_BITS + 3;       // 1 - c
    localparam int K2_W      = FRAC_BITS + 3;       // entries of K*K
    localparam int RW        = 2 * FRAC_BITS + 8;   // working width of products
    localparam int NDIV      = 5;

    // Divider lanes
    localparam int DIV_S  = 0;
    localparam int DIV_C  = 1;
    localparam int DIV_U0 = 2;

    localparam logic signed [RW-1:0] ONE_R  = RW'(longint'(1) << FRAC_BITS);
    localparam logic [QUO_W-1:0]     ONE_Q  = QUO_W'(longint'(1) << FRAC_BITS);
    localparam logic [RW-1:0]        HALF_R = RW'(longint'(1) << (FRAC_BITS - 1));

    // Operand data carried through the square root stages
    typedef struct packed {
        logic signed [CROSS_W-1:0] cr0;
        logic signed [CROSS_W-1:0] cr1;
        logic signed [CROSS_W-1:0] cr2;
        logic signed [DOT_W-1:0]   dot;
        logic                      deg;
    } vamr_side_t;

    // Signs carried through the divider stages
    typedef struct packed {
        logic sd;
        logic su0;
        logic su1;
        logic su2;
        logic deg;
    } vamr_sign_t;

    // Divide by 2^FRAC_BITS, rounding halves away from zero
    function automatic logic signed [RW-1:0] shr_rnd(input logic signed [RW-1:0] x);
        logic [RW-1:0] mag;
        logic [RW-1:0] q;
        mag = x[RW-1] ? RW'(-x) : RW'(x);
        q   = (mag + HALF_R) >> FRAC_BITS;
        return x[RW-1] ? -$signed(q) : $signed(q);
    endfunction

    // Saturate to [-1.0, +1.0]
    function automatic logic signed [OUT_W-1:0] clamp_one(input logic signed [RW-1:0] x);
        logic signed [OUT_W-1:0] res;
        if (x > ONE_R)
        begin
            res = OUT_W'(ONE_R);
        end
        else if (x < -ONE_R)
        begin
            res = OUT_W'(-ONE_R);
        end
        else
        begin
            res = OUT_W'(x);
        end
        return res;
    endfunction

endpackage

FILE: design/vamr_in_if.sv
`timescale 1ns / 1ps
// Input channel: one pair of vectors per transaction.
interface vamr_in_if;
    import vamr_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] first_x;
    logic signed [IN_W-1:0] first_y;
    logic signed [IN_W-1:0] first_z;
    logic signed [IN_W-1:0] second_x;
    logic signed [IN_W-1:0] second_y;
    logic signed [IN_W-1:0] second_z;

    modport source (
        output valid, first_x, first_y, first_z, second_x, second_y, second_z,
        input  ready
    );
    modport sink (
        input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
        output ready
    );
endinterface

FILE: design/vamr_out_if.sv
`timescale 1ns / 1ps
// Output channel: one rotation matrix and degenerate flag per transaction.
interface vamr_out_if;
    import vamr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] r00;
    logic signed [OUT_W-1:0] r01;
    logic signed [OUT_W-1:0] r02;
    logic signed [OUT_W-1:0] r10;
    logic signed [OUT_W-1:0] r11;
    logic signed [OUT_W-1:0] r12;
    logic signed [OUT_W-1:0] r20;
    logic signed [OUT_W-1:0] r21;
    logic signed [OUT_W-1:0] r22;
    logic                    degenerate;

    modport source (
        output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, degenerate,
        input  ready
    );
    modport sink (
        input  valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, degenerate,
        output ready
    );
endinterface

FILE: design/vector_align_rotation_matrix_unit.sv
`timescale 1ns / 1ps
// Top level: pipelined rotation matrix that aligns a first 3-vector with a second.
//
// vec_in carries two Q1.14 vectors per transaction; mat_out carries the nine Q1.14
// entries of R = I + s*K + (1-c)*K^2 and a degenerate flag. When the cross product
// is zero the result is the identity with degenerate set.
// An accepted input transaction reaches mat_out through registered stages of products
// and norms, bit-pair square root (two roots side by side), operand setup, restoring
// division (five lanes, one quotient bit per stage) and matrix assembly and saturation.
// Throughput is one transaction per cycle while mat_out keeps taking results. The whole
// pipeline moves together: when the output register holds a result that mat_out does
// not take, every stage holds and vec_in.ready drops in the same cycle; nothing is lost
// or repeated.
// Reset clears all stage valid bits; the data registers are not reset.
module vector_align_rotation_matrix_unit (
    input  logic clk,
    input  logic rst_n,
    vamr_in_if.sink    vec_in,
    vamr_out_if.source mat_out
);
    import vamr_pkg::*;

    localparam int ST_P  = 4 + ROOT_W;
    localparam int ST_E1 = ST_P + QUO_W + 1;
    localparam int NSTG  = ST_E1 + 5;

    // K*K entry lanes
    localparam int KI_00 = 0;
    localparam int KI_11 = 1;
    localparam int KI_22 = 2;
    localparam int KI_01 = 3;
    localparam int KI_02 = 4;
    localparam int KI_12 = 5;

    logic [NSTG-1:0] vld_reg;
    logic            adv;

    logic signed [IN_W-1:0] av [3];
    logic signed [IN_W-1:0] bv [3];

    logic signed [PROD_W-1:0] a_crp_reg [3];
    logic signed [PROD_W-1:0] a_crn_reg [3];
    logic signed [PROD_W-1:0] a_dot_reg [3];
    logic signed [PROD_W-1:0] a_aa_reg  [3];
    logic signed [PROD_W-1:0] a_bb_reg  [3];

    logic signed [CROSS_W-1:0] b_cr_reg [3];
    logic signed [DOT_W-1:0]   b_dot_reg;
    logic [MAG_W-1:0]          b_na_reg;
    logic [MAG_W-1:0]          b_nb_reg;
    logic                      b_deg_reg;

    logic [MAG_W-1:0] c_mag_next [3];
    logic [SQ_W-1:0]  c_sq_reg   [3];
    logic [SQ_W-1:0]  c_nn_reg;
    vamr_side_t       c_side_reg;

    logic [SQ_W-1:0] sq_vc_reg   [ROOT_W+1];
    logic [SQ_W-1:0] sq_rc_reg   [ROOT_W+1];
    logic [SQ_W-1:0] sq_vn_reg   [ROOT_W+1];
    logic [SQ_W-1:0] sq_rn_reg   [ROOT_W+1];
    vamr_side_t      sq_side_reg [ROOT_W+1];

    logic [ROOT_W-1:0] p_cn;
    logic [ROOT_W-1:0] p_nn;
    logic [ROOT_W-1:0] p_croot;
    logic [ROOT_W-1:0] p_nroot;
    logic [MAG_W-1:0]  p_dmag;
    logic [MAG_W-1:0]  p_cmag [3];
    vamr_side_t        p_side;

    logic [NUM_W-1:0]  dv_rem_reg [QUO_W+1][NDIV];
    logic [ROOT_W-1:0] dv_den_reg [QUO_W+1][NDIV];
    logic [QUO_W-1:0]  dv_q_reg   [QUO_W+1][NDIV];
    vamr_sign_t        dv_sign_reg[QUO_W+1];

    logic [QUO_W-1:0]   e1_qs;
    logic [QUO_W-1:0]   e1_qc;
    vamr_sign_t         e1_sign;
    logic signed [U_W-1:0] e1_s_reg;
    logic signed [U_W-1:0] e1_c_reg;
    logic signed [U_W-1:0] e1_u_reg [3];
    logic                  e1_deg_reg;

    logic signed [RW-1:0]    e2_p_reg  [6];
    logic signed [RW-1:0]    e2_su_reg [3];
    logic signed [OMC_W-1:0] e2_omc_reg;
    logic                    e2_deg_reg;

    logic signed [RW-1:0]    e3_uu;
    logic signed [K2_W-1:0]  e3_k2_reg [6];
    logic signed [U_W-1:0]   e3_sk_reg [3];
    logic signed [OMC_W-1:0] e3_omc_reg;
    logic                    e3_deg_reg;

    logic signed [RW-1:0]  e4_t_reg  [6];
    logic signed [U_W-1:0] e4_sk_reg [3];
    logic                  e4_deg_reg;

    logic signed [RW-1:0]    e5_tr [6];
    logic signed [RW-1:0]    e5_sk [3];
    logic signed [RW-1:0]    e5_sum [9];
    logic signed [OUT_W-1:0] out_r_reg [9];
    logic                    out_deg_reg;

    // Handshake: all stages advance together unless the output is stalled
    assign adv           = !vld_reg[NSTG-1] || mat_out.ready;
    assign vec_in.ready  = adv;
    assign mat_out.valid = vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], vec_in.valid};
        end
    end

    assign av[0] = vec_in.first_x;
    assign av[1] = vec_in.first_y;
    assign av[2] = vec_in.first_z;
    assign bv[0] = vec_in.second_x;
    assign bv[1] = vec_in.second_y;
    assign bv[2] = vec_in.second_z;

    // Stage A: all input products
    for (genvar i = 0; i < 3; i++)
    begin : g_prod
        localparam int I1 = (i + 1) % 3;
        localparam int I2 = (i + 2) % 3;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                a_crp_reg[i] <= PROD_W'(av[I1]) * PROD_W'(bv[I2]);
                a_crn_reg[i] <= PROD_W'(av[I2]) * PROD_W'(bv[I1]);
                a_dot_reg[i] <= PROD_W'(av[i]) * PROD_W'(bv[i]);
                a_aa_reg[i]  <= PROD_W'(av[i]) * PROD_W'(av[i]);
                a_bb_reg[i]  <= PROD_W'(bv[i]) * PROD_W'(bv[i]);
            end
        end
    end

    // Stage B: cross product, dot product, squared norms, degenerate flag
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                b_cr_reg[i] <= CROSS_W'(a_crp_reg[i]) - CROSS_W'(a_crn_reg[i]);
            end
            b_dot_reg <= DOT_W'(a_dot_reg[0]) + DOT_W'(a_dot_reg[1]) + DOT_W'(a_dot_reg[2]);
            b_na_reg  <= unsigned'(a_aa_reg[0]) + unsigned'(a_aa_reg[1])
                         + unsigned'(a_aa_reg[2]);
            b_nb_reg  <= unsigned'(a_bb_reg[0]) + unsigned'(a_bb_reg[1])
                         + unsigned'(a_bb_reg[2]);
            b_deg_reg <= (a_crp_reg[0] == a_crn_reg[0]) && (a_crp_reg[1] == a_crn_reg[1])
                         && (a_crp_reg[2] == a_crn_reg[2]);
        end
    end

    // Stage C: squared cross components and product of squared norms
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            c_mag_next[i] = b_cr_reg[i][CROSS_W-1] ? MAG_W'(-b_cr_reg[i])
                                                   : MAG_W'(b_cr_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                c_sq_reg[i] <= SQ_W'(c_mag_next[i]) * SQ_W'(c_mag_next[i]);
            end
            c_nn_reg       <= SQ_W'(b_na_reg) * SQ_W'(b_nb_reg);
            c_side_reg.cr0 <= b_cr_reg[0];
            c_side_reg.cr1 <= b_cr_reg[1];
            c_side_reg.cr2 <= b_cr_reg[2];
            c_side_reg.dot <= b_dot_reg;
            c_side_reg.deg <= b_deg_reg;
        end
    end

    // Stage D: |C|^2, loads both square root pipelines
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_vc_reg[0]   <= c_sq_reg[0] + c_sq_reg[1] + c_sq_reg[2];
            sq_rc_reg[0]   <= '0;
            sq_vn_reg[0]   <= c_nn_reg;
            sq_rn_reg[0]   <= '0;
            sq_side_reg[0] <= c_side_reg;
        end
    end

    // Square root: one result bit per stage for |C| and for |a||b|
    for (genvar k = 1; k <= ROOT_W; k++)
    begin : g_sqrt
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 * k);
        logic [SQ_W-1:0] tc;
        logic [SQ_W-1:0] tn;
        assign tc = sq_rc_reg[k-1] + BIT;
        assign tn = sq_rn_reg[k-1] + BIT;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_side_reg[k] <= sq_side_reg[k-1];
                if (sq_vc_reg[k-1] >= tc)
                begin
                    sq_vc_reg[k] <= sq_vc_reg[k-1] - tc;
                    sq_rc_reg[k] <= (sq_rc_reg[k-1] >> 1) + BIT;
                end
                else
                begin
                    sq_vc_reg[k] <= sq_vc_reg[k-1];
                    sq_rc_reg[k] <= sq_rc_reg[k-1] >> 1;
                end
                if (sq_vn_reg[k-1] >= tn)
                begin
                    sq_vn_reg[k] <= sq_vn_reg[k-1] - tn;
                    sq_rn_reg[k] <= (sq_rn_reg[k-1] >> 1) + BIT;
                end
                else
                begin
                    sq_vn_reg[k] <= sq_vn_reg[k-1];
                    sq_rn_reg[k] <= sq_rn_reg[k-1] >> 1;
                end
            end
        end
    end

    // Stage P: divider operands, numerator = mag * 2^F + den / 2
    assign p_side  = sq_side_reg[ROOT_W];
    assign p_croot = sq_rc_reg[ROOT_W][ROOT_W-1:0];
    assign p_nroot = sq_rn_reg[ROOT_W][ROOT_W-1:0];
    assign p_cn    = (p_croot == '0) ? ROOT_W'(1) : p_croot;
    assign p_nn    = (p_nroot == '0) ? ROOT_W'(1) : p_nroot;
    assign p_dmag  = p_side.dot[DOT_W-1] ? MAG_W'(-p_side.dot) : MAG_W'(p_side.dot);
    assign p_cmag[0] = p_side.cr0[CROSS_W-1] ? MAG_W'(-p_side.cr0) : MAG_W'(p_side.cr0);
    assign p_cmag[1] = p_side.cr1[CROSS_W-1] ? MAG_W'(-p_side.cr1) : MAG_W'(p_side.cr1);
    assign p_cmag[2] = p_side.cr2[CROSS_W-1] ? MAG_W'(-p_side.cr2) : MAG_W'(p_side.cr2);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_rem_reg[0][DIV_S] <= NUM_W'({p_cn, {FRAC_BITS{1'b0}}}) + NUM_W'(p_nn >> 1);
            dv_den_reg[0][DIV_S] <= p_nn;
            dv_rem_reg[0][DIV_C] <= NUM_W'({p_dmag, {FRAC_BITS{1'b0}}}) + NUM_W'(p_nn >> 1);
            dv_den_reg[0][DIV_C] <= p_nn;
            for (int i = 0; i < 3; i++)
            begin
                dv_rem_reg[0][DIV_U0+i] <= NUM_W'({p_cmag[i], {FRAC_BITS{1'b0}}})
                                           + NUM_W'(p_cn >> 1);
                dv_den_reg[0][DIV_U0+i] <= p_cn;
            end
            for (int j = 0; j < NDIV; j++)
            begin
                dv_q_reg[0][j] <= '0;
            end
            dv_sign_reg[0].sd  <= p_side.dot[DOT_W-1];
            dv_sign_reg[0].su0 <= p_side.cr0[CROSS_W-1];
            dv_sign_reg[0].su1 <= p_side.cr1[CROSS_W-1];
            dv_sign_reg[0].su2 <= p_side.cr2[CROSS_W-1];
            dv_sign_reg[0].deg <= p_side.deg;
        end
    end

    // Restoring division: one quotient bit per stage in five lanes
    for (genvar k = 1; k <= QUO_W; k++)
    begin : g_div
        localparam int BP = QUO_W - k;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_sign_reg[k] <= dv_sign_reg[k-1];
            end
        end
        for (genvar j = 0; j < NDIV; j++)
        begin : g_lane
            logic [NUM_W-1:0] trial;
            assign trial = NUM_W'(dv_den_reg[k-1][j]) << BP;
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_den_reg[k][j] <= dv_den_reg[k-1][j];
                    if (dv_rem_reg[k-1][j] >= trial)
                    begin
                        dv_rem_reg[k][j] <= dv_rem_reg[k-1][j] - trial;
                        dv_q_reg[k][j]   <= dv_q_reg[k-1][j] | (QUO_W'(1) << BP);
                    end
                    else
                    begin
                        dv_rem_reg[k][j] <= dv_rem_reg[k-1][j];
                        dv_q_reg[k][j]   <= dv_q_reg[k-1][j];
                    end
                end
            end
        end
    end

    // E1: clamps of s and c, signs of c and the unit axis
    assign e1_sign = dv_sign_reg[QUO_W];
    assign e1_qs   = (dv_q_reg[QUO_W][DIV_S] > ONE_Q) ? ONE_Q : dv_q_reg[QUO_W][DIV_S];
    assign e1_qc   = (dv_q_reg[QUO_W][DIV_C] > ONE_Q) ? ONE_Q : dv_q_reg[QUO_W][DIV_C];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_s_reg    <= U_W'(e1_qs);
            e1_c_reg    <= e1_sign.sd ? -U_W'(e1_qc) : U_W'(e1_qc);
            e1_u_reg[0] <= e1_sign.su0 ? -U_W'(dv_q_reg[QUO_W][DIV_U0])
                                       : U_W'(dv_q_reg[QUO_W][DIV_U0]);
            e1_u_reg[1] <= e1_sign.su1 ? -U_W'(dv_q_reg[QUO_W][DIV_U0+1])
                                       : U_W'(dv_q_reg[QUO_W][DIV_U0+1]);
            e1_u_reg[2] <= e1_sign.su2 ? -U_W'(dv_q_reg[QUO_W][DIV_U0+2])
                                       : U_W'(dv_q_reg[QUO_W][DIV_U0+2]);
            e1_deg_reg  <= e1_sign.deg;
        end
    end

    // E2: axis outer products, s*u and 1 - c
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e2_p_reg[KI_00] <= RW'(e1_u_reg[0]) * RW'(e1_u_reg[0]);
            e2_p_reg[KI_11] <= RW'(e1_u_reg[1]) * RW'(e1_u_reg[1]);
            e2_p_reg[KI_22] <= RW'(e1_u_reg[2]) * RW'(e1_u_reg[2]);
            e2_p_reg[KI_01] <= RW'(e1_u_reg[0]) * RW'(e1_u_reg[1]);
            e2_p_reg[KI_02] <= RW'(e1_u_reg[0]) * RW'(e1_u_reg[2]);
            e2_p_reg[KI_12] <= RW'(e1_u_reg[1]) * RW'(e1_u_reg[2]);
            for (int i = 0; i < 3; i++)
            begin
                e2_su_reg[i] <= RW'(e1_s_reg) * RW'(e1_u_reg[i]);
            end
            e2_omc_reg <= OMC_W'(ONE_R) - OMC_W'(e1_c_reg);
            e2_deg_reg <= e1_deg_reg;
        end
    end

    // E3: rounded K*K entries and s*K terms
    assign e3_uu = e2_p_reg[KI_00] + e2_p_reg[KI_11] + e2_p_reg[KI_22];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e3_k2_reg[KI_00] <= K2_W'(shr_rnd(e2_p_reg[KI_00] - e3_uu));
            e3_k2_reg[KI_11] <= K2_W'(shr_rnd(e2_p_reg[KI_11] - e3_uu));
            e3_k2_reg[KI_22] <= K2_W'(shr_rnd(e2_p_reg[KI_22] - e3_uu));
            e3_k2_reg[KI_01] <= K2_W'(shr_rnd(e2_p_reg[KI_01]));
            e3_k2_reg[KI_02] <= K2_W'(shr_rnd(e2_p_reg[KI_02]));
            e3_k2_reg[KI_12] <= K2_W'(shr_rnd(e2_p_reg[KI_12]));
            for (int i = 0; i < 3; i++)
            begin
                e3_sk_reg[i] <= U_W'(shr_rnd(e2_su_reg[i]));
            end
            e3_omc_reg <= e2_omc_reg;
            e3_deg_reg <= e2_deg_reg;
        end
    end

    // E4: (1 - c) * K*K
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int m = 0; m < 6; m++)
            begin
                e4_t_reg[m] <= RW'(e3_omc_reg) * RW'(e3_k2_reg[m]);
            end
            for (int i = 0; i < 3; i++)
            begin
                e4_sk_reg[i] <= e3_sk_reg[i];
            end
            e4_deg_reg <= e3_deg_reg;
        end
    end

    // E5: assemble, saturate, identity for a degenerate pair
    always_comb
    begin
        for (int m = 0; m < 6; m++)
        begin
            e5_tr[m] = shr_rnd(e4_t_reg[m]);
        end
        for (int i = 0; i < 3; i++)
        begin
            e5_sk[i] = RW'(e4_sk_reg[i]);
        end
        e5_sum[0] = ONE_R + e5_tr[KI_00];
        e5_sum[1] = e5_tr[KI_01] - e5_sk[2];
        e5_sum[2] = e5_tr[KI_02] + e5_sk[1];
        e5_sum[3] = e5_tr[KI_01] + e5_sk[2];
        e5_sum[4] = ONE_R + e5_tr[KI_11];
        e5_sum[5] = e5_tr[KI_12] - e5_sk[0];
        e5_sum[6] = e5_tr[KI_02] - e5_sk[1];
        e5_sum[7] = e5_tr[KI_12] + e5_sk[0];
        e5_sum[8] = ONE_R + e5_tr[KI_22];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int m = 0; m < 9; m++)
            begin
                if (e4_deg_reg)
                begin
                    out_r_reg[m] <= (m == 0 || m == 4 || m == 8) ? OUT_W'(ONE_R) : '0;
                end
                else
                begin
                    out_r_reg[m] <= clamp_one(e5_sum[m]);
                end
            end
            out_deg_reg <= e4_deg_reg;
        end
    end

    assign mat_out.r00        = out_r_reg[0];
    assign mat_out.r01        = out_r_reg[1];
    assign mat_out.r02        = out_r_reg[2];
    assign mat_out.r10        = out_r_reg[3];
    assign mat_out.r11        = out_r_reg[4];
    assign mat_out.r12        = out_r_reg[5];
    assign mat_out.r20        = out_r_reg[6];
    assign mat_out.r21        = out_r_reg[7];
    assign mat_out.r22        = out_r_reg[8];
    assign mat_out.degenerate = out_deg_reg;

endmodule

FILE: bench/vector_align_rotation_matrix_unit_tb.sv
`timescale 1ns / 1ps
// Testbench of the vector alignment rotation matrix unit: directed and random vector pairs.
module vector_align_rotation_matrix_unit_tb;
    import vamr_pkg::*;

    localparam int LATENCY   = 57;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 1500;

    typedef struct {
        logic signed [OUT_W-1:0] r [9];
        logic                    degenerate;
    } rot_mat_t;

    logic clk;
    logic rst_n;

    vamr_in_if  vec_in ();
    vamr_out_if mat_out ();

    vector_align_rotation_matrix_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .vec_in  (vec_in.sink),
        .mat_out (mat_out.source)
    );

    rot_mat_t expected_mats[$];
    int       error_count;
    int       idle_cycles;
    bit       sink_hold;
    bit       sink_no_stall;
    bit       src_no_gap;

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Integer square root, floor
    function automatic longint unsigned isqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // num * 2^F / den, halves away from zero
    function automatic longint scaled_div(input longint num, input longint unsigned den);
        longint unsigned mag;
        longint unsigned q;
        mag = (num < 0) ? -num : num;
        q   = ((mag << FRAC_BITS) + den / 2) / den;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    // x / 2^F, halves away from zero
    function automatic longint drop_frac(input longint x);
        longint unsigned mag;
        longint unsigned q;
        mag = (x < 0) ? -x : x;
        q   = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return (x < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Rotation that turns a onto b
    function automatic rot_mat_t align_rotation(input longint a[3], input longint b[3]);
        rot_mat_t        m;
        longint          one;
        longint          cr[3];
        longint          u[3];
        longint          k[3][3];
        longint          d, s, c, uu, k2, r;
        longint unsigned cc2, na2, nb2, cn, nn;
        one   = longint'(1) << FRAC_BITS;
        cr[0] = a[1] * b[2] - a[2] * b[1];
        cr[1] = a[2] * b[0] - a[0] * b[2];
        cr[2] = a[0] * b[1] - a[1] * b[0];
        if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0)
        begin
            for (int i = 0; i < 9; i++)
                m.r[i] = (i % 4 == 0) ? OUT_W'(one) : '0;
            m.degenerate = 1'b1;
            return m;
        end
        d   = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        cc2 = cr[0] * cr[0] + cr[1] * cr[1] + cr[2] * cr[2];
        na2 = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        nb2 = b[0] * b[0] + b[1] * b[1] + b[2] * b[2];
        cn  = isqrt(cc2);
        nn  = isqrt(na2 * nb2);
        if (cn == 0) cn = 1;
        if (nn == 0) nn = 1;
        s = scaled_div(longint'(cn), nn);
        c = scaled_div(d, nn);
        if (s > one) s = one;
        if (c > one) c = one;
        if (c < -one) c = -one;
        for (int i = 0; i < 3; i++)
            u[i] = scaled_div(cr[i], cn);
        k[0][0] = 0;     k[0][1] = -u[2]; k[0][2] = u[1];
        k[1][0] = u[2];  k[1][1] = 0;     k[1][2] = -u[0];
        k[2][0] = -u[1]; k[2][1] = u[0];  k[2][2] = 0;
        uu = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                k2 = drop_frac(u[i] * u[j] - ((i == j) ? uu : 0));
                r  = ((i == j) ? one : 0) + drop_frac(s * k[i][j]) + drop_frac((one - c) * k2);
                if (r > one) r = one;
                if (r < -one) r = -one;
                m.r[i * 3 + j] = OUT_W'(r);
            end
        end
        m.degenerate = 1'b0;
        return m;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    function automatic int short_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    endfunction

    // Offer one pair of vectors and wait for its transaction; valid stays high
    // for a back-to-back follower and drops only during a gap
    task automatic send_pair(input logic [15:0] ax, ay, az, bx, by, bz);
        longint a[3];
        longint b[3];
        int     gap;
        gap = src_no_gap ? 0 : (($urandom_range(0, 1) == 0) ? 0 : short_gap());
        if (gap != 0)
        begin
            vec_in.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        vec_in.valid    <= 1'b1;
        vec_in.first_x  <= ax;
        vec_in.first_y  <= ay;
        vec_in.first_z  <= az;
        vec_in.second_x <= bx;
        vec_in.second_y <= by;
        vec_in.second_z <= bz;
        do
            @(posedge clk);
        while (!vec_in.ready);
        a = '{longint'($signed(ax)), longint'($signed(ay)), longint'($signed(az))};
        b = '{longint'($signed(bx)), longint'($signed(by)), longint'($signed(bz))};
        expected_mats.push_back(align_rotation(a, b));
        @(negedge clk);
    endtask

    task automatic drain();
        vec_in.valid <= 1'b0;
        while (expected_mats.size() != 0)
            @(negedge clk);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        rot_mat_t want;
        logic signed [OUT_W-1:0] got[9];
        if (mat_out.valid && mat_out.ready)
        begin
            got = '{mat_out.r00, mat_out.r01, mat_out.r02, mat_out.r10, mat_out.r11,
                    mat_out.r12, mat_out.r20, mat_out.r21, mat_out.r22};
            if (expected_mats.size() == 0)
            begin
                report_mismatch("unexpected transaction", 1, 0);
            end
            else
            begin
                want = expected_mats.pop_front();
                for (int i = 0; i < 9; i++)
                    if (got[i] !== want.r[i])
                        report_mismatch($sformatf("r%0d%0d", i / 3, i % 3), got[i], want.r[i]);
                if (mat_out.degenerate !== want.degenerate)
                    report_mismatch("degenerate", mat_out.degenerate, want.degenerate);
            end
        end
    end

    // Receiver ready with random stalls
    initial
    begin
        mat_out.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (sink_hold)
            begin
                mat_out.ready <= 1'b0;
            end
            else if (sink_no_stall || $urandom_range(0, 3) != 0)
            begin
                mat_out.ready <= 1'b1;
            end
            else
            begin
                mat_out.ready <= 1'b0;
                repeat (short_gap()) @(negedge clk);
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((vec_in.valid && vec_in.ready) || (mat_out.valid && mat_out.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [15:0] edge_val();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'h4000;
            4: return 16'hC000;
            default: return 16'(int'($urandom_range(0, 6)) - 3);
        endcase
    endfunction

    task automatic test_directed();
        send_pair(16'h4000, 0, 0, 0, 16'h4000, 0);
        send_pair(0, 16'h4000, 0, 0, 0, 16'h4000);
        send_pair(0, 0, 16'h4000, 16'h4000, 0, 0);
        // parallel, antiparallel and zero vectors
        send_pair(16'h4000, 16'h2000, 0, 16'h2000, 16'h1000, 0);
        send_pair(16'h4000, 16'h2000, 0, 16'hC000, 16'hE000, 0);
        send_pair(0, 0, 0, 16'h1234, 16'h0567, 16'h0089);
        send_pair(16'h0100, 16'h0200, 16'h0300, 0, 0, 0);
        // extremes of the fields
        send_pair(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        send_pair(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000);
        send_pair(16'h8000, 0, 0, 0, 16'h7FFF, 0);
        send_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001, 16'hFFFF);
        send_pair(16'h0001, 0, 0, 0, 0, 16'h0001);
        // nearly antiparallel, nearly parallel and nearly orthogonal
        send_pair(16'h4000, 16'h0001, 0, 16'hC000, 0, 0);
        send_pair(16'h4000, 0, 0, 16'h4000, 16'h0001, 0);
        send_pair(16'h5A82, 16'h5A82, 0, 16'h8000, 16'h7FFF, 16'h0001);
        send_pair(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
        drain();
    endtask

    task automatic test_random();
        logic [15:0] v[6];
        for (int n = 0; n < N_RANDOM; n++)
        begin
            for (int i = 0; i < 6; i++)
                v[i] = ($urandom_range(0, 7) == 0) ? edge_val() : 16'($urandom);
            // occasional parallel pair
            if ($urandom_range(0, 15) == 0)
            begin
                v[3] = v[0];
                v[4] = v[1];
                v[5] = v[2];
            end
            sink_no_stall = (n / 200) % 3 == 1;
            send_pair(v[0], v[1], v[2], v[3], v[4], v[5]);
        end
        drain();
    endtask

    // Receiver holds off while the sender keeps offering back to back
    task automatic test_backpressure();
        src_no_gap = 1'b1;
        sink_hold  = 1'b1;
        fork
            begin
                repeat (LATENCY + 100) @(negedge clk);
                sink_hold = 1'b0;
            end
            begin
                for (int n = 0; n < 120; n++)
                    send_pair(16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom), 16'($urandom));
            end
        join
        src_no_gap = 1'b0;
        drain();
    endtask

    initial
    begin
        error_count     = 0;
        idle_cycles     = 0;
        sink_hold       = 1'b0;
        sink_no_stall   = 1'b0;
        src_no_gap      = 1'b0;
        rst_n           = 1'b0;
        vec_in.valid    = 1'b0;
        vec_in.first_x  = '0;
        vec_in.first_y  = '0;
        vec_in.first_z  = '0;
        vec_in.second_x = '0;
        vec_in.second_y = '0;
        vec_in.second_z = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_backpressure();
        test_random();
        repeat (LATENCY + 20) @(negedge clk);
        if (error_count == 0 && expected_mats.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: files.f
design/vamr_pkg.sv
design/vamr_in_if.sv
design/vamr_out_if.sv
design/vector_align_rotation_matrix_unit.sv
bench/vector_align_rotation_matrix_unit_tb.sv
